// File: hw/rtl/dspd_pkg.sv
// ----------------------------------------------------------------------------
// dspd_pkg
// Shared types and constants for the dual side PID drive unit.
// ----------------------------------------------------------------------------
package dspd_pkg;

    // Gain format: unsigned Q0.16, speed = floor(sum / 2^(GAIN_FRAC+1))
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int SHIFT      = GAIN_FRAC + 1;

    // Integral accumulator, split in two halves for the multiplier
    localparam int INTEG_W    = 48;
    localparam int INTEG_HALF = INTEG_W / 2;

    // Full weighted sum width: gain times integral plus headroom
    localparam int TOT_W      = INTEG_W + GAIN_W + 2;

    localparam int SPEED_W    = 8;
    localparam int LIMIT_W    = 7;
    localparam int STOP_W     = 16;
    localparam logic [LIMIT_W-1:0] SPEED_MAX = 7'd100;

    // Result transfer packing: left, right, done, padded to bytes
    localparam int OUT_BITS   = 2 * SPEED_W + 1;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    // Stages: error, integral, multiply, partial sum, clamp, output
    localparam int PIPE_DEPTH = 6;

    // Configuration register indexes
    localparam int REG_IDX_W  = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET      = 3'd0,
        REG_GAIN_P      = 3'd1,
        REG_GAIN_I      = 3'd2,
        REG_GAIN_D      = 3'd3,
        REG_STOP_BAND   = 3'd4,
        REG_SPEED_LIMIT = 3'd5
    } dspd_reg_idx_t;

    // Reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd6554;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd1704;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd6554;
    localparam logic [STOP_W-1:0]  STOP_BAND_RST   = 16'd20;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 7'd95;

    // Gain and limit settings shared by both lanes
    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [STOP_W-1:0]  stop_band;
        logic [LIMIT_W-1:0] speed_limit;
    } dspd_cfg_t;

    // Per-stage load enables driven by the top level pipeline control
    typedef struct packed {
        logic ld_err;
        logic ld_integ;
        logic ld_mult;
        logic ld_sum;
        logic ld_clamp;
    } dspd_lane_en_t;

endpackage

// File: hw/rtl/dual_side_pid_drive_unit.sv
// ----------------------------------------------------------------------------
// dual_side_pid_drive_unit
// Two-lane PID drive controller, left and right sides side by side.
//
//   Port group   Dir  Contents
//   s_*          in   tick: restart, left front/back, right front/back pos
//   m_*          out  result: left speed, right speed, done
//   cfg_*        in   register write: target, gains, stop band, speed limit
//
// One tick is accepted per cycle while s_tready is high; a result passes
// through the six register stages (error, integral, multiply, partial
// sum, clamp, output) before its transfer. The integral update is a
// loop that closes within stage 2, so ticks may follow back to back.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes both
// integrals and previous errors, and loads register defaults.
// A stalled result holds in the output stage; earlier stages keep filling
// and s_tready drops only when all six stages hold a tick.
// ----------------------------------------------------------------------------
module dual_side_pid_drive_unit #(
    parameter int POS_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // restart, left_front_pos, left_back_pos, right_front_pos,
    // right_back_pos (lowest bit up), zero padded
    input  logic [((4*POS_BITS+8)/8)*8-1:0]   s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // left_speed, right_speed, done_res (lowest bit up), zero padded
    output logic [dspd_pkg::OUT_W-1:0]        m_tdata,

    input  logic                              cfg_wr_en,
    input  logic [dspd_pkg::REG_IDX_W-1:0]    cfg_addr,
    input  logic [((POS_BITS > 16) ? POS_BITS : 16)-1:0] cfg_wdata
);

    localparam int ND = dspd_pkg::PIPE_DEPTH;
    localparam int SP = dspd_pkg::SPEED_W;

    // ---------------- configuration registers ----------------
    logic signed [POS_BITS-1:0] target_reg;
    dspd_pkg::dspd_cfg_t        cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg          <= '0;
            cfg_reg.gain_p      <= dspd_pkg::GAIN_P_RST;
            cfg_reg.gain_i      <= dspd_pkg::GAIN_I_RST;
            cfg_reg.gain_d      <= dspd_pkg::GAIN_D_RST;
            cfg_reg.stop_band   <= dspd_pkg::STOP_BAND_RST;
            cfg_reg.speed_limit <= dspd_pkg::SPEED_LIMIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dspd_pkg::REG_TARGET:      target_reg          <= cfg_wdata[POS_BITS-1:0];
                dspd_pkg::REG_GAIN_P:      cfg_reg.gain_p      <= cfg_wdata[15:0];
                dspd_pkg::REG_GAIN_I:      cfg_reg.gain_i      <= cfg_wdata[15:0];
                dspd_pkg::REG_GAIN_D:      cfg_reg.gain_d      <= cfg_wdata[15:0];
                dspd_pkg::REG_STOP_BAND:   cfg_reg.stop_band   <= cfg_wdata[15:0];
                dspd_pkg::REG_SPEED_LIMIT: cfg_reg.speed_limit <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [ND-1:0] vld_reg;
    logic [ND-1:0] rdy;
    logic [ND-1:0] ld;

    // a stage can load when it is empty or its tick moves on
    always_comb begin
        rdy[ND-1] = !vld_reg[ND-1] || m_tready;
        for (int i = ND - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        ld[0] = s_tvalid && rdy[0];
        for (int i = 1; i < ND; i++) begin
            ld[i] = vld_reg[i-1] && rdy[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < ND; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= ld[i];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[ND-1];

    dspd_pkg::dspd_lane_en_t lane_en;
    assign lane_en.ld_err   = ld[0];
    assign lane_en.ld_integ = ld[1];
    assign lane_en.ld_mult  = ld[2];
    assign lane_en.ld_sum   = ld[3];
    assign lane_en.ld_clamp = ld[4];

    // ---------------- input unpacking ----------------
    logic                       in_restart;
    logic signed [POS_BITS-1:0] in_lf;
    logic signed [POS_BITS-1:0] in_lb;
    logic signed [POS_BITS-1:0] in_rf;
    logic signed [POS_BITS-1:0] in_rb;

    assign in_restart = s_tdata[0];
    assign in_lf      = s_tdata[1 +: POS_BITS];
    assign in_lb      = s_tdata[1 + POS_BITS +: POS_BITS];
    assign in_rf      = s_tdata[1 + 2*POS_BITS +: POS_BITS];
    assign in_rb      = s_tdata[1 + 3*POS_BITS +: POS_BITS];

    // ---------------- lanes ----------------
    logic signed [SP-1:0] left_lane_spd;
    logic signed [SP-1:0] right_lane_spd;
    logic                 left_lane_stop;
    logic                 right_lane_stop;

    dspd_lane #(.POS_BITS(POS_BITS)) u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (lane_en),
        .cfg       (cfg_reg),
        .target    (target_reg),
        .restart   (in_restart),
        .front_pos (in_lf),
        .back_pos  (in_lb),
        .speed     (left_lane_spd),
        .stop      (left_lane_stop)
    );

    dspd_lane #(.POS_BITS(POS_BITS)) u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (lane_en),
        .cfg       (cfg_reg),
        .target    (target_reg),
        .restart   (in_restart),
        .front_pos (in_rf),
        .back_pos  (in_rb),
        .speed     (right_lane_spd),
        .stop      (right_lane_stop)
    );

    // ---------------- merge and output register ----------------
    logic signed [SP-1:0] out_left;
    logic signed [SP-1:0] out_right;
    logic                 out_done;

    dspd_merge u_merge (
        .aclk        (aclk),
        .ld          (ld[ND-1]),
        .target_neg  (target_reg[POS_BITS-1]),
        .left_in     (left_lane_spd),
        .left_stop   (left_lane_stop),
        .right_in    (right_lane_spd),
        .right_stop  (right_lane_stop),
        .left_speed  (out_left),
        .right_speed (out_right),
        .done_res    (out_done)
    );

    assign m_tdata = {{(dspd_pkg::OUT_W - dspd_pkg::OUT_BITS){1'b0}},
                      out_done, out_right, out_left};

endmodule

// File: hw/rtl/dspd_lane.sv
// ----------------------------------------------------------------------------
// dspd_lane
// One side's PID datapath: error, saturating integral, derivative, gain
// products, floored sum and clamp. Five register stages.
// ----------------------------------------------------------------------------
module dspd_lane #(
    parameter int POS_BITS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dspd_pkg::dspd_lane_en_t             en,
    input  dspd_pkg::dspd_cfg_t                 cfg,
    input  logic signed [POS_BITS-1:0]          target,
    input  logic                                restart,
    input  logic signed [POS_BITS-1:0]          front_pos,
    input  logic signed [POS_BITS-1:0]          back_pos,
    output logic signed [dspd_pkg::SPEED_W-1:0] speed,
    output logic                                stop
);

    localparam int EW = POS_BITS + 2;               // error
    localparam int DW = POS_BITS + 3;               // derivative
    localparam int CW = EW + dspd_pkg::STOP_W + 2;  // stop compare
    localparam int PW = EW + dspd_pkg::GAIN_W + 1;  // P product
    localparam int QW = DW + dspd_pkg::GAIN_W + 1;  // D product
    localparam int AW = QW + 1;                     // P + D
    localparam int IW = dspd_pkg::INTEG_W;
    localparam int HW = dspd_pkg::INTEG_HALF;
    localparam int TW = dspd_pkg::TOT_W;
    localparam int SW = TW - dspd_pkg::SHIFT;       // scaled sum
    localparam int LW = dspd_pkg::LIMIT_W;

    // ---------------- stage 1: error ----------------
    logic signed [EW-1:0] tgt2;
    logic signed [EW-1:0] pos_sum;
    logic signed [EW-1:0] err_c;
    logic signed [EW-1:0] err1_reg;
    logic                 rst1_reg;

    always_comb begin
        tgt2    = {target[POS_BITS-1], target, 1'b0};
        pos_sum = {{2{front_pos[POS_BITS-1]}}, front_pos}
                + {{2{back_pos[POS_BITS-1]}}, back_pos};
        err_c   = tgt2 - pos_sum;
    end

    always_ff @(posedge aclk) begin
        if (en.ld_err) begin
            err1_reg <= err_c;
            rst1_reg <= restart;
        end
    end

    // ---------------- stage 2: integral, derivative, stop ----------------
    logic signed [IW-1:0] integ_reg;
    logic signed [IW-1:0] integ_next;
    logic signed [EW-1:0] prev_reg;
    logic signed [IW-1:0] integ_base;
    logic signed [EW-1:0] prev_base;
    logic signed [IW:0]   integ_sum;
    logic signed [DW-1:0] diff_c;
    logic                 stop_c;
    logic signed [EW-1:0] err2_reg;
    logic signed [DW-1:0] diff2_reg;
    logic signed [IW-1:0] integ2_reg;
    logic                 stop2_reg;

    always_comb begin
        integ_base = rst1_reg ? '0 : integ_reg;
        prev_base  = rst1_reg ? '0 : prev_reg;
        integ_sum  = (IW+1)'(integ_base) + (IW+1)'(err1_reg);
        // saturate on signed overflow
        if (integ_sum[IW] != integ_sum[IW-1]) begin
            integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            integ_next = integ_sum[IW-1:0];
        end
        diff_c = DW'(err1_reg) - DW'(prev_base);
        // position >= 2*target - 2*stop_band  <=>  error <= 2*stop_band
        stop_c = (CW'(err1_reg) <= $signed({2'b00, cfg.stop_band, 1'b0}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end else if (en.ld_integ) begin
            integ_reg <= integ_next;
            prev_reg  <= err1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_integ) begin
            err2_reg   <= err1_reg;
            diff2_reg  <= diff_c;
            integ2_reg <= integ_next;
            stop2_reg  <= stop_c;
        end
    end

    // ---------------- stage 3: gain products ----------------
    logic signed [PW-1:0]          p3_reg;
    logic signed [QW-1:0]          d3_reg;
    logic signed [HW+dspd_pkg::GAIN_W:0] ihi3_reg;
    logic [HW+dspd_pkg::GAIN_W-1:0]      ilo3_reg;
    logic                          stop3_reg;

    always_ff @(posedge aclk) begin
        if (en.ld_mult) begin
            p3_reg    <= $signed({1'b0, cfg.gain_p}) * err2_reg;
            d3_reg    <= $signed({1'b0, cfg.gain_d}) * diff2_reg;
            ihi3_reg  <= $signed({1'b0, cfg.gain_i}) * $signed(integ2_reg[IW-1:HW]);
            ilo3_reg  <= cfg.gain_i * integ2_reg[HW-1:0];
            stop3_reg <= stop2_reg;
        end
    end

    // ---------------- stage 4: partial sums ----------------
    logic signed [AW-1:0] pd4_reg;
    logic signed [TW-1:0] i4_reg;
    logic                 stop4_reg;

    always_ff @(posedge aclk) begin
        if (en.ld_sum) begin
            pd4_reg   <= AW'(p3_reg) + AW'(d3_reg);
            i4_reg    <= (TW'(ihi3_reg) <<< HW) + $signed(TW'(ilo3_reg));
            stop4_reg <= stop3_reg;
        end
    end

    // ---------------- stage 5: total, floor shift, clamp ----------------
    logic signed [TW-1:0] total;
    logic signed [SW-1:0] scaled;
    logic [LW-1:0]        lim;
    logic signed [SW-1:0] lim_pos;
    logic signed [SW-1:0] lim_neg;
    logic signed [SW-1:0] clamped;
    logic signed [dspd_pkg::SPEED_W-1:0] speed5_reg;
    logic                 stop5_reg;

    always_comb begin
        total   = TW'(pd4_reg) + i4_reg;
        scaled  = total[TW-1:dspd_pkg::SHIFT];   // arithmetic shift = floor
        lim     = (cfg.speed_limit > dspd_pkg::SPEED_MAX) ? dspd_pkg::SPEED_MAX
                                                          : cfg.speed_limit;
        lim_pos = $signed({{(SW-LW){1'b0}}, lim});
        lim_neg = -lim_pos;
        if (scaled > lim_pos) begin
            clamped = lim_pos;
        end else if (scaled < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.ld_clamp) begin
            speed5_reg <= clamped[dspd_pkg::SPEED_W-1:0];
            stop5_reg  <= stop4_reg;
        end
    end

    assign speed = speed5_reg;
    assign stop  = stop5_reg;

endmodule

// File: hw/rtl/dspd_merge.sv
// ----------------------------------------------------------------------------
// dspd_merge
// Combines the two lane results: stop band override, sign for a negative
// target, done flag, and the result output register.
// ----------------------------------------------------------------------------
module dspd_merge (
    input  logic                                aclk,
    input  logic                                ld,
    input  logic                                target_neg,
    input  logic signed [dspd_pkg::SPEED_W-1:0] left_in,
    input  logic                                left_stop,
    input  logic signed [dspd_pkg::SPEED_W-1:0] right_in,
    input  logic                                right_stop,
    output logic signed [dspd_pkg::SPEED_W-1:0] left_speed,
    output logic signed [dspd_pkg::SPEED_W-1:0] right_speed,
    output logic                                done_res
);

    logic signed [dspd_pkg::SPEED_W-1:0] left_gate;
    logic signed [dspd_pkg::SPEED_W-1:0] right_gate;
    logic signed [dspd_pkg::SPEED_W-1:0] left_c;
    logic signed [dspd_pkg::SPEED_W-1:0] right_c;
    logic signed [dspd_pkg::SPEED_W-1:0] left_reg;
    logic signed [dspd_pkg::SPEED_W-1:0] right_reg;
    logic                                done_reg;

    // stop band override, then sign flip for a negative target
    always_comb begin
        left_gate  = left_stop  ? '0 : left_in;
        right_gate = right_stop ? '0 : right_in;
        left_c     = target_neg ? -left_gate  : left_gate;
        right_c    = target_neg ? -right_gate : right_gate;
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            left_reg  <= left_c;
            right_reg <= right_c;
            done_reg  <= (left_c == '0) && (right_c == '0);
        end
    end

    assign left_speed  = left_reg;
    assign right_speed = right_reg;
    assign done_res    = done_reg;

endmodule

// File: hw/rtl/dspd_checker.sv
// ----------------------------------------------------------------------------
// dspd_checker
// Port-level checks on the result channel of the PID drive unit.
// ----------------------------------------------------------------------------
module dspd_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [dspd_pkg::OUT_W-1:0] m_tdata
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a held result keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // clamp keeps both speeds within one hundred percent
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[7:0]) >= -8'sd100) &&
                     ($signed(m_tdata[7:0]) <= 8'sd100) &&
                     ($signed(m_tdata[15:8]) >= -8'sd100) &&
                     ($signed(m_tdata[15:8]) <= 8'sd100))
        else $error("speed outside limit");

    // done matches both speeds at zero
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[16] == ((m_tdata[7:0] == 8'd0) && (m_tdata[15:8] == 8'd0))))
        else $error("done flag disagrees with speeds");

endmodule

bind dual_side_pid_drive_unit dspd_checker u_dspd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/pid_drive_checker.sv
// ----------------------------------------------------------------------------
// pid_drive_checker
// Watches the tick, result and register write ports of the dual side PID
// drive unit. It keeps its own copy of the registers and of each side's
// integral and last error, works out the speed command that every accepted
// tick must produce, and compares the result transfers in order, field by
// field.
// ----------------------------------------------------------------------------
module pid_drive_checker #(
    parameter int POS_BITS = 24
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_tvalid,
    input  logic                                         s_tready,
    input  logic [((4*POS_BITS+8)/8)*8-1:0]              s_tdata,
    input  logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic [dspd_pkg::OUT_W-1:0]                   m_tdata,
    input  logic                                         cfg_wr_en,
    input  logic [dspd_pkg::REG_IDX_W-1:0]               cfg_addr,
    input  logic [((POS_BITS > 16) ? POS_BITS : 16)-1:0] cfg_wdata,
    output int                                           fail_count,
    output int                                           speeds_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SPEED_W    = dspd_pkg::SPEED_W;
    localparam int     SHIFT      = dspd_pkg::SHIFT;
    localparam longint INTEG_MAX  = (longint'(1) << (dspd_pkg::INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    // integral high part beyond this bound already pins the clamp
    localparam int     HI_Q_BOUND = 46;
    localparam int     HI_SAT     = 62;

    typedef struct {
        logic signed [SPEED_W-1:0] left;
        logic signed [SPEED_W-1:0] right;
        logic                      done;
    } speed_cmd_t;

    speed_cmd_t speeds_due[$];

    // register copy
    logic signed [POS_BITS-1:0]          target_deg  = '0;
    logic [dspd_pkg::GAIN_W-1:0]         kp          = dspd_pkg::GAIN_P_RST;
    logic [dspd_pkg::GAIN_W-1:0]         ki          = dspd_pkg::GAIN_I_RST;
    logic [dspd_pkg::GAIN_W-1:0]         kd          = dspd_pkg::GAIN_D_RST;
    logic [dspd_pkg::STOP_W-1:0]         stop_band   = dspd_pkg::STOP_BAND_RST;
    logic [dspd_pkg::LIMIT_W-1:0]        speed_limit = dspd_pkg::SPEED_LIMIT_RST;

    // per side state, index 0 left, 1 right
    longint lane_integ[2];
    longint lane_last_err[2];
    int     mismatches = 0;

    // One side: error, saturating integral, derivative, weighted sum, clamp,
    // stop test and sign flip for a negative target.
    function automatic longint lane_speed(int lane, longint pos_sum, bit restart);
        longint gp, gi, gd, sb, tgt2, err, diff, q, frac, hi_term, low_sum, spd, lim;
        gp   = kp;
        gi   = ki;
        gd   = kd;
        sb   = stop_band;
        tgt2 = 2 * longint'(target_deg);
        err  = tgt2 - pos_sum;
        if (restart) begin
            lane_integ[lane]    = 0;
            lane_last_err[lane] = 0;
        end
        if (err > 0 && lane_integ[lane] > INTEG_MAX - err)
            lane_integ[lane] = INTEG_MAX;
        else if (err < 0 && lane_integ[lane] < INTEG_MIN - err)
            lane_integ[lane] = INTEG_MIN;
        else
            lane_integ[lane] = lane_integ[lane] + err;
        diff                = err - lane_last_err[lane];
        lane_last_err[lane] = err;

        // integral split into a floored high part and the low fraction bits
        q    = lane_integ[lane] >>> SHIFT;
        frac = lane_integ[lane] & ((longint'(1) << SHIFT) - 1);
        if (gi == 0)
            hi_term = 0;
        else if (q >= (longint'(1) << HI_Q_BOUND))
            hi_term = longint'(1) << HI_SAT;
        else if (q <= -(longint'(1) << HI_Q_BOUND))
            hi_term = -(longint'(1) << HI_SAT);
        else
            hi_term = gi * q;
        low_sum = gp * err + gd * diff + gi * frac;
        spd     = hi_term + (low_sum >>> SHIFT);

        lim = (speed_limit > dspd_pkg::SPEED_MAX) ? dspd_pkg::SPEED_MAX : speed_limit;
        if (spd > lim)
            spd = lim;
        if (spd < -lim)
            spd = -lim;
        if (pos_sum >= tgt2 - 2 * sb)
            spd = 0;
        if (target_deg < 0)
            spd = -spd;
        return spd;
    endfunction

    always @(posedge aclk) begin
        speed_cmd_t due, got;
        longint     lsum, rsum, lspd, rspd;
        bit         restart;
        if (!aresetn) begin
            target_deg  = '0;
            kp          = dspd_pkg::GAIN_P_RST;
            ki          = dspd_pkg::GAIN_I_RST;
            kd          = dspd_pkg::GAIN_D_RST;
            stop_band   = dspd_pkg::STOP_BAND_RST;
            speed_limit = dspd_pkg::SPEED_LIMIT_RST;
            for (int i = 0; i < 2; i++) begin
                lane_integ[i]    = 0;
                lane_last_err[i] = 0;
            end
            speeds_due.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    dspd_pkg::REG_TARGET:
                        target_deg  = cfg_wdata[POS_BITS-1:0];
                    dspd_pkg::REG_GAIN_P:
                        kp          = cfg_wdata[dspd_pkg::GAIN_W-1:0];
                    dspd_pkg::REG_GAIN_I:
                        ki          = cfg_wdata[dspd_pkg::GAIN_W-1:0];
                    dspd_pkg::REG_GAIN_D:
                        kd          = cfg_wdata[dspd_pkg::GAIN_W-1:0];
                    dspd_pkg::REG_STOP_BAND:
                        stop_band   = cfg_wdata[dspd_pkg::STOP_W-1:0];
                    dspd_pkg::REG_SPEED_LIMIT:
                        speed_limit = cfg_wdata[dspd_pkg::LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest expected command
            if (m_tvalid && m_tready) begin
                got.left  = m_tdata[SPEED_W-1:0];
                got.right = m_tdata[2*SPEED_W-1:SPEED_W];
                got.done  = m_tdata[2*SPEED_W];
                if (speeds_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result left %0d right %0d done %0b",
                             $time, got.left, got.right, got.done);
                end else begin
                    due = speeds_due.pop_front();
                    if (got.left !== due.left) begin
                        mismatches++;
                        $display("%0t: left_speed expected %0d actual %0d",
                                 $time, due.left, got.left);
                    end
                    if (got.right !== due.right) begin
                        mismatches++;
                        $display("%0t: right_speed expected %0d actual %0d",
                                 $time, due.right, got.right);
                    end
                    if (got.done !== due.done) begin
                        mismatches++;
                        $display("%0t: done_res expected %0b actual %0b",
                                 $time, due.done, got.done);
                    end
                end
            end

            // tick transfer: left side then right side, as the state updates
            if (s_tvalid && s_tready) begin
                restart = s_tdata[0];
                lsum = longint'($signed(s_tdata[POS_BITS:1]))
                     + longint'($signed(s_tdata[2*POS_BITS:POS_BITS+1]));
                rsum = longint'($signed(s_tdata[3*POS_BITS:2*POS_BITS+1]))
                     + longint'($signed(s_tdata[4*POS_BITS:3*POS_BITS+1]));
                lspd = lane_speed(0, lsum, restart);
                rspd = lane_speed(1, rsum, restart);
                due.left  = lspd[SPEED_W-1:0];
                due.right = rspd[SPEED_W-1:0];
                due.done  = (lspd == 0 && rspd == 0);
                speeds_due.push_back(due);
            end
        end
        fail_count     <= mismatches;
        speeds_pending <= speeds_due.size();
    end

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the dual side PID drive unit. Runs a few register settings,
// defaults and extremes among them, each with drive runs that approach the
// target from a random start, plus noise ticks and broken runs. The sender
// works in bursts and the receiver stalls on its own pattern; the checker
// beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     POS_BITS     = 24;
    localparam int     TICK_W       = ((4*POS_BITS+8)/8)*8;
    localparam int     CFG_W        = (POS_BITS > 16) ? POS_BITS : 16;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     NUM_PHASES   = 7;
    localparam int     RANDOM_TICKS = 132;
    localparam longint POS_MAX      = (longint'(1) << (POS_BITS - 1)) - 1;
    localparam longint POS_MIN      = -POS_MAX - 1;
    localparam int     GAIN_TOP     = (1 << dspd_pkg::GAIN_W) - 1;
    localparam int     STOP_TOP     = (1 << dspd_pkg::STOP_W) - 1;
    localparam int     LIMIT_TOP    = (1 << dspd_pkg::LIMIT_W) - 1;
    localparam int     SPEED_TOP    = int'(dspd_pkg::SPEED_MAX);

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [TICK_W-1:0]          s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [dspd_pkg::OUT_W-1:0] m_tdata;
    logic                       cfg_wr_en;
    dspd_pkg::dspd_reg_idx_t    cfg_addr;
    logic [CFG_W-1:0]           cfg_wdata;

    int                  fail_count;
    int                  speeds_pending;
    int                  cycle_count = 0;
    logic [TICK_W-1:0]   ticks_todo[$];
    longint              goal_deg;
    bit                  sender_calm;

    dual_side_pid_drive_unit #(.POS_BITS(POS_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pid_drive_checker #(.POS_BITS(POS_BITS)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .speeds_pending (speeds_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: stall pattern picked anew after each random span
    initial begin
        int mode, span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 400);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 9) == 0);
                    default: m_tready <= ((cycle_count % 8) < 5);
                endcase
            end
        end
    end

    function automatic logic [POS_BITS-1:0] sat_pos(longint p);
        if (p > POS_MAX)
            return POS_MAX[POS_BITS-1:0];
        if (p < POS_MIN)
            return POS_MIN[POS_BITS-1:0];
        return p[POS_BITS-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] pack_tick(bit restart, longint lf, longint lb,
                                                    longint rf, longint rb);
        logic [TICK_W-1:0] v;
        v                                = '0;
        v[0]                             = restart;
        v[POS_BITS:1]                    = sat_pos(lf);
        v[2*POS_BITS:POS_BITS+1]         = sat_pos(lb);
        v[3*POS_BITS:2*POS_BITS+1]       = sat_pos(rf);
        v[4*POS_BITS:3*POS_BITS+1]       = sat_pos(rb);
        return v;
    endfunction

    function automatic longint rand_pos();
        logic signed [POS_BITS-1:0] r;
        r = POS_BITS'($urandom);
        return r;
    endfunction

    // A drive run: restart, then the wheels creep toward the goal with
    // a little jitter, the right side offset from the left by a skew. Some runs
    // skip the restart or restart halfway, some start past the goal.
    task automatic add_run(output int count);
        int     len;
        longint span, center, stride, skew;
        bit     skip_restart;
        len          = $urandom_range(8, 40);
        skip_restart = ($urandom_range(0, 9) == 0);
        skew         = longint'($urandom_range(0, 100)) - 50;
        case ($urandom_range(0, 3))
            0:       span = 200;
            1:       span = 5000;
            2:       span = 300000;
            default: span = POS_MAX;
        endcase
        if ($urandom_range(0, 5) == 0)
            center = goal_deg + longint'($urandom_range(0, 2000));
        else
            center = goal_deg - longint'($urandom_range(0, span));
        for (int i = 0; i < len; i++) begin
            ticks_todo.push_back(pack_tick(
                (i == 0 && !skip_restart) || ($urandom_range(0, 32) == 0),
                center + longint'($urandom_range(0, 6)) - 3,
                center + longint'($urandom_range(0, 6)) - 3,
                center + skew + longint'($urandom_range(0, 6)) - 3,
                center + skew + longint'($urandom_range(0, 6)) - 3));
            stride = (goal_deg - center) * 2 / len;
            if (stride < 8)
                stride = 8;
            if (stride > 32'h7fff_ffff)
                stride = 32'h7fff_ffff;
            center = center + longint'($urandom_range(0, stride));
        end
        count = len;
    endtask

    // noise tick: raw bits, extremes or values near the goal
    function automatic longint noise_pos();
        case ($urandom_range(0, 4))
            0:       return POS_MIN;
            1:       return POS_MAX;
            2:       return goal_deg + longint'($urandom_range(0, 200)) - 100;
            default: return rand_pos();
        endcase
    endfunction

    task automatic send_ticks();
        int burst_left, gap;
        burst_left = 0;
        while (ticks_todo.size() != 0) begin
            if (burst_left == 0) begin
                gap = sender_calm ? 0 : $urandom_range(0, 12);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 24);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= ticks_todo.pop_front();
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            @(negedge aclk);
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    // wait until every expected result is out, then let the pipe drain
    task automatic settle();
        while (speeds_pending != 0)
            @(posedge aclk);
        repeat (dspd_pkg::PIPE_DEPTH) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(dspd_pkg::dspd_reg_idx_t idx, longint value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(negedge aclk);
    endtask

    task automatic write_settings(longint tgt, int gp, int gi, int gd, int sb, int lim);
        write_reg(dspd_pkg::REG_TARGET, tgt);
        write_reg(dspd_pkg::REG_GAIN_P, gp);
        write_reg(dspd_pkg::REG_GAIN_I, gi);
        write_reg(dspd_pkg::REG_GAIN_D, gd);
        write_reg(dspd_pkg::REG_STOP_BAND, sb);
        write_reg(dspd_pkg::REG_SPEED_LIMIT, lim);
        cfg_wr_en <= 1'b0;
        goal_deg = tgt;
    endtask

    initial begin
        int added, run_len;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = dspd_pkg::REG_TARGET;
        cfg_wdata = '0;
        goal_deg  = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            if (phase != 0)
                settle();
            case (phase)
                0: ;    // register defaults
                1: write_settings(POS_MAX, GAIN_TOP, GAIN_TOP, GAIN_TOP, 0, SPEED_TOP);
                2: write_settings(POS_MIN, 0, 0, 0, STOP_TOP, LIMIT_TOP);
                3: write_settings(longint'($urandom_range(1000, 200000)),
                                  $urandom_range(0, 20000), $urandom_range(0, 20000),
                                  $urandom_range(0, 20000), $urandom_range(0, 200),
                                  $urandom_range(1, 100));
                4: write_settings(-longint'($urandom_range(1000, 200000)),
                                  $urandom_range(0, 20000), $urandom_range(0, 20000),
                                  $urandom_range(0, 20000), $urandom_range(0, 200),
                                  $urandom_range(0, LIMIT_TOP));
                5: write_settings(rand_pos(), $urandom_range(0, GAIN_TOP),
                                  $urandom_range(0, GAIN_TOP), $urandom_range(0, GAIN_TOP),
                                  $urandom_range(0, STOP_TOP), 0);
                default: write_settings(longint'($urandom_range(0, 400000)) - 200000,
                                        $urandom_range(0, GAIN_TOP),
                                        $urandom_range(0, GAIN_TOP),
                                        $urandom_range(0, GAIN_TOP),
                                        $urandom_range(0, 1000),
                                        $urandom_range(SPEED_TOP + 1, LIMIT_TOP));
            endcase

            if (phase == 0) begin
                ticks_todo.push_back(pack_tick(1, 0, 0, 0, 0));
                ticks_todo.push_back(pack_tick(0, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
                ticks_todo.push_back(pack_tick(0, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
                ticks_todo.push_back(pack_tick(0, POS_MIN, POS_MIN, POS_MAX, POS_MAX));
                ticks_todo.push_back(pack_tick(0, POS_MAX, POS_MIN, POS_MIN, POS_MAX));
                // stop band edge: a sum of -40 stops, -41 still drives
                ticks_todo.push_back(pack_tick(1, -20, -20, -20, -21));
                ticks_todo.push_back(pack_tick(0, -21, -20, -20, -20));
                // steady approach
                ticks_todo.push_back(pack_tick(1, -1000, -1000, -1000, -1000));
                ticks_todo.push_back(pack_tick(0, -1000, -1000, -990, -990));
                ticks_todo.push_back(pack_tick(0, -700, -700, -600, -600));
                // large error then close in: derivative swings hard negative
                ticks_todo.push_back(pack_tick(0, POS_MIN, POS_MIN, -5000, -5000));
                ticks_todo.push_back(pack_tick(0, -100, -100, -30, -30));
                // alternating bit patterns
                ticks_todo.push_back(pack_tick(0, 24'h555555, -24'sh555556,
                                               -24'sh555556, 24'h555555));
                ticks_todo.push_back(pack_tick(0, -24'sh555556, 24'h555555,
                                               24'h555555, -24'sh555556));
                // restart mid-run, then hold still
                ticks_todo.push_back(pack_tick(1, -300, -300, -300, -300));
                ticks_todo.push_back(pack_tick(0, -300, -300, -300, -300));
                ticks_todo.push_back(pack_tick(0, -1, 0, 0, -1));
            end else begin
                ticks_todo.push_back(pack_tick(1, POS_MIN, POS_MIN, POS_MIN, POS_MIN));
                ticks_todo.push_back(pack_tick(0, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
                ticks_todo.push_back(pack_tick(0, goal_deg, goal_deg, goal_deg, goal_deg));
            end

            // mostly drive runs, some noise
            added = 0;
            while (added < RANDOM_TICKS) begin
                if ($urandom_range(0, 3) != 0) begin
                    add_run(run_len);
                    added += run_len;
                end else begin
                    ticks_todo.push_back(pack_tick($urandom_range(0, 7) == 0, noise_pos(),
                                                   noise_pos(), noise_pos(), noise_pos()));
                    added++;
                end
            end
            send_ticks();
        end

        settle();
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
